// ----- hdl/ktiv_pkg.sv -----
// Package for the keyframe track interpolator: sizes, payload types, status codes.
`default_nettype none
package ktiv_pkg;

  localparam int unsigned MAX_KEYS  = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_KEYS);
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned VEC_W     = 3 * VAL_W;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BEYOND = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_W-1:0]       key_slot;
    logic [TIME_W-1:0]       key_time;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
    logic [TIME_W-1:0]       query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_x;
    logic signed [VAL_W-1:0] result_y;
    logic signed [VAL_W-1:0] result_z;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
    logic signed [VAL_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic                 start;
    vec_t                 a;
    vec_t                 b;
    logic [FRAC_BITS-1:0] factor;
  } lerp_req_t;

  typedef struct packed {
    logic done;
    vec_t res;
  } lerp_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/ktiv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ktiv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/ktiv_div.sv -----
// Restoring divider, one quotient bit per cycle, for the interpolation factor.
`default_nettype none
module ktiv_div import ktiv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(FRAC_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic [TIME_W-1:0]    rem_q;
  logic [TIME_W-1:0]    den_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [TIME_W:0]      rem2;
  logic                 ge;

  // remainder stays below the divisor, so doubling fits one extra bit
  assign rem2 = {rem_q, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= ge ? TIME_W'(rem2 - {1'b0, den_q}) : TIME_W'(rem2);
      quot_q <= {quot_q[FRAC_BITS-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

// ----- hdl/ktiv_lerp.sv -----
// Shared multiply-add unit: blends start and end keys one component at a time.
`default_nettype none
module ktiv_lerp import ktiv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lerp_req_t req_i,
  output lerp_rsp_t rsp_o
);

  localparam int unsigned PW = VAL_W + 1 + FRAC_BITS + 1;

  logic                    busy_q;
  logic                    phase_q;
  logic                    done_q;
  logic [1:0]              comp_q;
  logic signed [PW-1:0]    prod_q;
  vec_t                    res_q;
  logic signed [VAL_W-1:0] a_c;
  logic signed [VAL_W-1:0] b_c;
  logic signed [VAL_W:0]   delta;
  logic signed [FRAC_BITS:0] fs;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    shifted;
  logic signed [VAL_W-1:0] sum;

  always_comb begin
    case (comp_q)
      2'd0: begin
        a_c = req_i.a.x;
        b_c = req_i.b.x;
      end
      2'd1: begin
        a_c = req_i.a.y;
        b_c = req_i.b.y;
      end
      default: begin
        a_c = req_i.a.z;
        b_c = req_i.b.z;
      end
    endcase
  end

  assign delta   = $signed({b_c[VAL_W-1], b_c}) - $signed({a_c[VAL_W-1], a_c});
  assign fs      = $signed({1'b0, req_i.factor});
  assign prod    = delta * fs;
  // arithmetic shift floors toward minus infinity
  assign shifted = prod_q >>> FRAC_BITS;
  assign sum     = a_c + shifted[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      comp_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        comp_q  <= '0;
      end else if (busy_q) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          if (comp_q == 2'd2) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            comp_q <= comp_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !phase_q) begin
      prod_q <= prod;
    end
    if (busy_q && phase_q) begin
      case (comp_q)
        2'd0:    res_q.x <= sum;
        2'd1:    res_q.y <= sum;
        default: res_q.z <= sum;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule
`default_nettype wire

// ----- hdl/keyframe_track_interpolator.sv -----
// Keyframe track interpolator top level: key memories, search sequencer, output register.
//
// Channels: in_* carries write and query transactions (valid/stall), out_* carries one
// result per query, cfg_* writes key_count (always ready, write only while idle).
// A key write is taken without holding the input and writes the time and value memories
// at once; the block is ready again on the next cycle.
// A query scans the time memory one key per cycle (one read port, registered read data),
// then a bit-serial divider forms the factor and a shared multiplier blends x, y and z
// one after another, with a multiply step and a sum step for each. A time inside the
// interval from key n-1 to key n blends those two keys; a time past the last key, a zero
// interval, a time before the first key and a single key return a stored key value.
// in_stall_o is high while a query runs.
// Results go to an output register: a stalled result holds, and the block still takes
// new transactions; a further finished result waits until the register frees.
// Reset clears control state and sets key_count to 1; key memories are not cleared and
// must be written before they are queried.
`default_nettype none
module keyframe_track_interpolator import ktiv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [COUNT_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SEARCH = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_KEYRD  = 8'b0000_1000,
    S_KEYCAP = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_LERP   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q;
  logic [TIME_W-1:0]  q_q;
  idx_t               last_q;
  idx_t               issue_q;
  idx_t               chk_q;
  logic               chk_vld_q;
  logic [TIME_W-1:0]  prev_t_q;
  logic [TIME_W-1:0]  t0_q;
  logic [TIME_W-1:0]  t1_q;
  idx_t               i_q;
  idx_t               key_q;
  logic [1:0]         status_q;
  logic [1:0]         vcnt_q;
  vec_t               va_q;
  vec_t               vb_q;
  vec_t               res_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic              in_acc;
  logic              slot_ok;
  logic [31:0]       cnt_ext;
  logic [31:0]       n32;
  logic              single;
  logic [TIME_W-1:0] t_rdata;
  logic [VEC_W-1:0]  v_rdata;
  idx_t              t_raddr;
  idx_t              v_raddr;
  idx_t              waddr;
  logic              we;
  logic              hit;
  logic              miss_end;
  logic              zero_iv;
  logic              early;
  logic              load;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  lerp_req_t         lerp_req;
  lerp_rsp_t         lerp_rsp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  assign slot_ok = 32'(in_data_i.key_slot) < 32'(MAX_KEYS);
  assign waddr   = IDX_W'(in_data_i.key_slot);
  assign we      = in_acc && (in_data_i.kind == KIND_WRITE) && slot_ok;

  assign cnt_ext = 32'(count_q);
  assign n32     = (cnt_ext == 32'd0) ? 32'd1 :
                   (cnt_ext > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : cnt_ext;
  assign single  = (n32 == 32'd1);

  assign t_raddr = issue_q;
  assign v_raddr = (state_q == S_DIV) ? ((vcnt_q == 2'd0) ? i_q : i_q + 1'b1) : key_q;

  assign hit      = chk_vld_q && (chk_q != '0) && (q_q < t_rdata);
  assign miss_end = chk_vld_q && !hit && (chk_q == last_q);
  assign zero_iv  = (t1_q <= t0_q);
  assign early    = (q_q < t0_q);
  assign load     = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  ktiv_ram #(.WIDTH(TIME_W), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.key_time),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  ktiv_ram #(.WIDTH(VEC_W), .DEPTH(MAX_KEYS)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({in_data_i.value_x, in_data_i.value_y, in_data_i.value_z}),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  assign div_req.start = (state_q == S_DECIDE) && !zero_iv && !early;
  assign div_req.num   = q_q - t0_q;
  assign div_req.den   = t1_q - t0_q;

  ktiv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign lerp_req.start  = (state_q == S_DIV) && div_rsp.done;
  assign lerp_req.a      = va_q;
  assign lerp_req.b      = vb_q;
  assign lerp_req.factor = div_rsp.quot;

  ktiv_lerp u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lerp_req),
    .rsp_o  (lerp_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.kind == KIND_QUERY)) begin
          state_d = single ? S_KEYRD : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_d = S_DECIDE;
        end else if (miss_end) begin
          state_d = S_KEYRD;
        end
      end
      S_DECIDE: state_d = (zero_iv || early) ? S_KEYRD : S_DIV;
      S_KEYRD:  state_d = S_KEYCAP;
      S_KEYCAP: state_d = S_FINISH;
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_LERP;
        end
      end
      S_LERP: begin
        if (lerp_rsp.done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= COUNT_W'(1);
      chk_vld_q   <= 1'b0;
      vcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      chk_vld_q <= (state_q == S_SEARCH) && !hit && !miss_end;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (state_q != S_DIV) begin
        vcnt_q <= '0;
      end else if (vcnt_q != 2'd3) begin
        vcnt_q <= vcnt_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        q_q      <= in_data_i.query_time;
        last_q   <= IDX_W'(n32 - 32'd1);
        issue_q  <= '0;
        key_q    <= '0;
        status_q <= ST_OK;
      end
      S_SEARCH: begin
        if (issue_q != last_q) begin
          issue_q <= issue_q + 1'b1;
        end
        chk_q <= issue_q;
        if (chk_vld_q) begin
          prev_t_q <= t_rdata;
        end
        if (hit) begin
          t0_q <= prev_t_q;
          t1_q <= t_rdata;
          i_q  <= chk_q - 1'b1;
        end else if (miss_end) begin
          key_q    <= last_q;
          status_q <= ST_BEYOND;
        end
      end
      S_DECIDE: begin
        key_q    <= i_q;
        status_q <= zero_iv ? ST_ZERO : ST_OK;
      end
      S_KEYCAP: res_q <= vec_t'(v_rdata);
      S_DIV: begin
        if (vcnt_q == 2'd1) begin
          va_q <= vec_t'(v_rdata);
        end
        if (vcnt_q == 2'd2) begin
          vb_q <= vec_t'(v_rdata);
        end
      end
      S_LERP: begin
        if (lerp_rsp.done) begin
          res_q <= lerp_rsp.res;
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      out_q.result_x <= res_q.x;
      out_q.result_y <= res_q.y;
      out_q.result_z <= res_q.z;
      out_q.status   <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- hdl/ktiv_checker.sv -----
// Port-level assertions for the keyframe track interpolator, bound to the top level.
`default_nettype none
module ktiv_checker import ktiv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [COUNT_W-1:0] cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_item_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_item_t          out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.status == ST_BEYOND ||
                     out_data_o.status == ST_ZERO))
    else $error("bad status code");

  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.kind == KIND_WRITE) |=> !in_stall_o)
    else $error("key write transaction held the input");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.kind == KIND_QUERY) |=> in_stall_o)
    else $error("query transaction did not occupy the block");

endmodule

bind keyframe_track_interpolator ktiv_checker u_ktiv_checker (.*);
`default_nettype wire
